[rtl/qhc_pkg.sv]
package qhc_pkg;

  // default coordinate format, signed q8.15 in 24 bits
  localparam int unsigned QHC_COORD_BITS = 24;
  localparam int unsigned QHC_FRAC_BITS  = 15;

  // depth of the queue between classifier and sequencer
  localparam int unsigned QHC_FIFO_DEPTH = 2;

  // polygon entry codes: a*4+b, a == b selects vertex a, else edge point between a and b
  localparam logic [3:0] C_V0  = 4'd0;
  localparam logic [3:0] C_V1  = 4'd5;
  localparam logic [3:0] C_V2  = 4'd10;
  localparam logic [3:0] C_V3  = 4'd15;
  localparam logic [3:0] C_E01 = 4'd1;
  localparam logic [3:0] C_E03 = 4'd3;
  localparam logic [3:0] C_E10 = 4'd4;
  localparam logic [3:0] C_E12 = 4'd6;
  localparam logic [3:0] C_E21 = 4'd9;
  localparam logic [3:0] C_E23 = 4'd11;
  localparam logic [3:0] C_E30 = 4'd12;
  localparam logic [3:0] C_E32 = 4'd14;
  localparam logic [3:0] C_NONE = 4'd0;

  typedef logic [2:0] vidx_t;

  // element 0 is the first polygon vertex
  typedef logic [4:0][3:0] qhc_row_t;

  // classification of one quad: sign pattern and polygon size
  typedef struct packed {
    logic [3:0] cfg;
    vidx_t      count;
  } qhc_class_t;

  // polygon size for each sign pattern; nothing above and the two crossed patterns give zero
  function automatic vidx_t qhc_count(input logic [3:0] cfg);
    vidx_t n;
    unique case (cfg)
      4'd1, 4'd2, 4'd4, 4'd8:           n = 3'd3;
      4'd3, 4'd6, 4'd9, 4'd12, 4'd15:   n = 3'd4;
      4'd7, 4'd11, 4'd13, 4'd14:        n = 3'd5;
      default:                          n = 3'd0;
    endcase
    return n;
  endfunction

  // polygon vertex list for each sign pattern, first vertex in element 0
  function automatic qhc_row_t qhc_row(input logic [3:0] cfg);
    qhc_row_t r;
    unique case (cfg)
      4'd1:    r = {C_NONE, C_NONE, C_E30, C_E10, C_V0};
      4'd2:    r = {C_NONE, C_NONE, C_E21, C_V1, C_E01};
      4'd3:    r = {C_NONE, C_E30, C_E21, C_V1, C_V0};
      4'd4:    r = {C_NONE, C_NONE, C_V2, C_E12, C_E32};
      4'd6:    r = {C_NONE, C_E32, C_V2, C_V1, C_E01};
      4'd7:    r = {C_E30, C_E32, C_V2, C_V1, C_V0};
      4'd8:    r = {C_NONE, C_NONE, C_V3, C_E23, C_E03};
      4'd9:    r = {C_NONE, C_V3, C_E23, C_E10, C_V0};
      4'd11:   r = {C_V3, C_E23, C_E21, C_V1, C_V0};
      4'd12:   r = {C_NONE, C_V3, C_V2, C_E12, C_E03};
      4'd13:   r = {C_V3, C_V2, C_E12, C_E10, C_V0};
      4'd14:   r = {C_E03, C_V3, C_V2, C_V1, C_E01};
      4'd15:   r = {C_NONE, C_V3, C_V2, C_V1, C_V0};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/quad_horizon_clipper_core.sv]
// a quad is queued; its vertices pass the stage 1, stage 2 and result registers
// the polygon's vertices follow on consecutive cycles, one per cycle
// the sequencer pops a quad once it has issued its last vertex, or one result if empty
// a two-entry queue takes new quads while the sequencer works; busy is high when it is full
// reset: synchronous rst empties the queue, clears the sequencer and the pipeline valid bits
module quad_horizon_clipper_core #(
  parameter int unsigned COORD_BITS = qhc_pkg::QHC_COORD_BITS,
  parameter int unsigned FRAC_BITS  = qhc_pkg::QHC_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] v0_x,
  input  logic signed [COORD_BITS-1:0] v0_y,
  input  logic signed [COORD_BITS-1:0] v0_z,
  input  logic signed [COORD_BITS-1:0] v1_x,
  input  logic signed [COORD_BITS-1:0] v1_y,
  input  logic signed [COORD_BITS-1:0] v1_z,
  input  logic signed [COORD_BITS-1:0] v2_x,
  input  logic signed [COORD_BITS-1:0] v2_y,
  input  logic signed [COORD_BITS-1:0] v2_z,
  input  logic signed [COORD_BITS-1:0] v3_x,
  input  logic signed [COORD_BITS-1:0] v3_y,
  input  logic signed [COORD_BITS-1:0] v3_z,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z,
  output logic [2:0]                   vertex_index,
  output logic [2:0]                   vertex_count,
  output logic                         last_vertex
);
  import qhc_pkg::*;

  localparam int unsigned VW = 12 * COORD_BITS;
  localparam int unsigned EW = VW + $bits(qhc_class_t);

  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  qhc_class_t    cls;
  qhc_class_t    head_cls;
  logic [EW-1:0] wr_entry;
  logic [EW-1:0] rd_entry;

  // front: handshake and classification
  qhc_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .start(start),
    .full (full),
    .z0   (v0_z),
    .z1   (v1_z),
    .z2   (v2_z),
    .z3   (v3_z),
    .busy (busy),
    .push (push),
    .cls  (cls)
  );

  // queue entry: class over the twelve coordinates, vertex 0 x lowest
  assign wr_entry = {cls, v3_z, v3_y, v3_x, v2_z, v2_y, v2_x,
                     v1_z, v1_y, v1_x, v0_z, v0_y, v0_x};

  qhc_fifo #(
    .WIDTH(EW)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(wr_entry),
    .pop  (pop),
    .rdata(rd_entry),
    .empty(empty),
    .full (full)
  );

  assign head_cls = rd_entry[EW-1:VW];

  // back: polygon sequencer and edge point arithmetic
  qhc_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (~empty),
    .head_vtx    (rd_entry[VW-1:0]),
    .head_cls    (head_cls),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .vertex_index(vertex_index),
    .vertex_count(vertex_count),
    .last_vertex (last_vertex)
  );

endmodule

[rtl/qhc_front.sv]
module qhc_front #(
  parameter int unsigned COORD_BITS = qhc_pkg::QHC_COORD_BITS
) (
  input  logic                         start,
  input  logic                         full,
  input  logic signed [COORD_BITS-1:0] z0,
  input  logic signed [COORD_BITS-1:0] z1,
  input  logic signed [COORD_BITS-1:0] z2,
  input  logic signed [COORD_BITS-1:0] z3,
  output logic                         busy,
  output logic                         push,
  output qhc_pkg::qhc_class_t          cls
);
  import qhc_pkg::*;

  logic [3:0] above;

  // handshake: take a quad whenever the queue has room
  assign busy = full;
  assign push = start & ~full;

  // sign pattern, zero z counts as below
  always_comb begin
    above[0] = (z0 > 0);
    above[1] = (z1 > 0);
    above[2] = (z2 > 0);
    above[3] = (z3 > 0);
    cls.cfg   = above;
    cls.count = qhc_count(above);
  end

endmodule

[rtl/qhc_fifo.sv]
module qhc_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);
  import qhc_pkg::*;

  localparam int unsigned DEPTH = QHC_FIFO_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  assign empty = (fill == '0);
  assign full  = (fill == CW'(DEPTH));
  assign rdata = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[rtl/qhc_back.sv]
module qhc_back #(
  parameter int unsigned COORD_BITS = qhc_pkg::QHC_COORD_BITS,
  parameter int unsigned FRAC_BITS  = qhc_pkg::QHC_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  input  logic [12*COORD_BITS-1:0]       head_vtx,
  input  qhc_pkg::qhc_class_t            head_cls,
  output logic                           pop,
  output logic                           out_valid,
  output logic signed [COORD_BITS-1:0]   out_x,
  output logic signed [COORD_BITS-1:0]   out_y,
  output logic signed [COORD_BITS-1:0]   out_z,
  output logic [2:0]                     vertex_index,
  output logic [2:0]                     vertex_count,
  output logic                           last_vertex
);
  import qhc_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned PW = 2 * CB;
  localparam int unsigned DW = 2 * CB + 1;
  localparam logic signed [DW-1:0] SAT_HI = {{(CB + 2){1'b0}}, {(CB - 1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_LO = {{(CB + 2){1'b1}}, {(CB - 1){1'b0}}};

  // sequencer over the polygon of the head quad
  vidx_t      k;
  vidx_t      k_next;
  logic       seq_last;
  qhc_row_t   row;
  logic [3:0] code;
  logic [1:0] sel_a;
  logic [1:0] sel_b;

  logic signed [CB-1:0] vtx [4][3];

  // stage 1: selected operands
  logic                 s1_valid;
  logic                 s1_pass;
  logic                 s1_empty;
  vidx_t                s1_idx;
  vidx_t                s1_cnt;
  logic                 s1_last;
  logic signed [CB-1:0] s1_az;
  logic signed [CB-1:0] s1_bz;
  logic signed [CB-1:0] s1_ac [3];
  logic signed [CB-1:0] s1_bc [3];

  // stage 2: products
  logic                 s2_valid;
  logic                 s2_pass;
  logic                 s2_empty;
  vidx_t                s2_idx;
  vidx_t                s2_cnt;
  logic                 s2_last;
  logic signed [CB-1:0] s2_val [3];
  logic signed [PW-1:0] s2_p [3];
  logic signed [PW-1:0] s2_q [3];

  // stage 3 inputs
  logic signed [DW-1:0] diff [3];
  logic signed [DW-1:0] shr [3];
  logic signed [CB-1:0] res [3];

  // unpack the head quad
  always_comb begin
    for (int v = 0; v < 4; v++) begin
      for (int c = 0; c < 3; c++) begin
        vtx[v][c] = head_vtx[(v * 3 + c) * CB +: CB];
      end
    end
  end

  // current polygon entry
  always_comb begin
    row      = qhc_row(head_cls.cfg);
    code     = row[k];
    sel_a    = code[3:2];
    sel_b    = code[1:0];
    seq_last = (head_cls.count == '0) || (k == head_cls.count - 1'b1);
    pop      = head_valid & seq_last;
    k_next   = pop ? '0 : (head_valid ? k + 1'b1 : k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else begin
      k <= k_next;
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_pass  <= (sel_a == sel_b);
    s1_empty <= (head_cls.count == '0);
    s1_idx   <= k;
    s1_cnt   <= head_cls.count;
    s1_last  <= seq_last;
    s1_az    <= vtx[sel_a][2];
    s1_bz    <= vtx[sel_b][2];
    for (int c = 0; c < 3; c++) begin
      s1_ac[c] <= vtx[sel_a][c];
      s1_bc[c] <= vtx[sel_b][c];
    end
  end

  // stage 2 registers: cross products b.z*a.c and a.z*b.c
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_pass  <= s1_pass;
    s2_empty <= s1_empty;
    s2_idx   <= s1_idx;
    s2_cnt   <= s1_cnt;
    s2_last  <= s1_last;
    for (int c = 0; c < 3; c++) begin
      s2_val[c] <= s1_ac[c];
      s2_p[c]   <= PW'(s1_bz) * PW'(s1_ac[c]);
      s2_q[c]   <= PW'(s1_az) * PW'(s1_bc[c]);
    end
  end

  // difference, floor shift and saturation; empty polygons give zero, vertex entries pass through
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = DW'(s2_p[c]) - DW'(s2_q[c]);
      shr[c]  = diff[c] >>> FRAC_BITS;
      if (s2_empty) begin
        res[c] = '0;
      end else if (s2_pass) begin
        res[c] = s2_val[c];
      end else if (shr[c] > SAT_HI) begin
        res[c] = SAT_HI[CB-1:0];
      end else if (shr[c] < SAT_LO) begin
        res[c] = SAT_LO[CB-1:0];
      end else begin
        res[c] = shr[c][CB-1:0];
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_x        <= res[0];
    out_y        <= res[1];
    out_z        <= res[2];
    vertex_index <= s2_idx;
    vertex_count <= s2_cnt;
    last_vertex  <= s2_last;
  end

endmodule

[rtl/qhc_checker.sv]
module qhc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic [2:0] vertex_index,
  input logic [2:0] vertex_count,
  input logic       last_vertex
);

  // nothing leaves the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result strobe right after reset");

  // a polygon's vertices come back to back with rising index and fixed count
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_vertex |=> out_valid && !$past(rst)
      && vertex_index == $past(vertex_index) + 3'd1
      && vertex_count == $past(vertex_count))
    else $error("polygon transaction broken up");

  // the last vertex closes the polygon at its count
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_vertex && vertex_count != 3'd0
      |-> vertex_index == vertex_count - 3'd1)
    else $error("last vertex index does not match count");

  // an empty polygon is a single result
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && vertex_count == 3'd0 |-> last_vertex && vertex_index == 3'd0)
    else $error("empty polygon result malformed");

  // only sizes 0, 3, 4 and 5 occur
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> vertex_count == 3'd0 || vertex_count == 3'd3
      || vertex_count == 3'd4 || vertex_count == 3'd5)
    else $error("impossible vertex count");

endmodule

bind quad_horizon_clipper_core qhc_checker u_qhc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .vertex_index(vertex_index),
  .vertex_count(vertex_count),
  .last_vertex (last_vertex)
);

[tb/tb_quad_horizon_clipper_core.sv]
module tb_quad_horizon_clipper_core;
  import qhc_pkg::*;

  localparam int unsigned CW = QHC_COORD_BITS;
  localparam int unsigned FW = QHC_FRAC_BITS;
  localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint CMIN = -(longint'(1) << (CW - 1));
  localparam int RANDOM_QUADS = 470;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } point_t;

  typedef point_t [3:0] quad_t;

  // one polygon vertex as it leaves the block
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [2:0]           idx;
    logic [2:0]           cnt;
    logic                 last;
  } vertex_t;

  // expected polygons and their comparison against the result strobe
  class clip_scoreboard;
    vertex_t expected_vertices[$];
    int      mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // edge point b.z*a - a.z*b on one component, floored and saturated
    static function coord_t edge_coord(coord_t az, coord_t ac, coord_t bz, coord_t bc);
      longint diff;
      diff = longint'($signed(bz)) * longint'($signed(ac))
           - longint'($signed(az)) * longint'($signed(bc));
      diff = diff >>> FW;
      if (diff > CMAX) diff = CMAX;
      if (diff < CMIN) diff = CMIN;
      return coord_t'(diff);
    endfunction

    // vertex list of the clipped polygon, first entry at position 0
    static function int polygon_of(logic [3:0] above, output logic [0:4][3:0] seq);
      int n;
      seq = '0;
      n = 0;
      case (above)
        4'd1:  begin seq = {C_V0, C_E10, C_E30, C_NONE, C_NONE}; n = 3; end
        4'd2:  begin seq = {C_E01, C_V1, C_E21, C_NONE, C_NONE}; n = 3; end
        4'd3:  begin seq = {C_V0, C_V1, C_E21, C_E30, C_NONE}; n = 4; end
        4'd4:  begin seq = {C_E32, C_E12, C_V2, C_NONE, C_NONE}; n = 3; end
        4'd6:  begin seq = {C_E01, C_V1, C_V2, C_E32, C_NONE}; n = 4; end
        4'd7:  begin seq = {C_V0, C_V1, C_V2, C_E32, C_E30}; n = 5; end
        4'd8:  begin seq = {C_E03, C_E23, C_V3, C_NONE, C_NONE}; n = 3; end
        4'd9:  begin seq = {C_V0, C_E10, C_E23, C_V3, C_NONE}; n = 4; end
        4'd11: begin seq = {C_V0, C_V1, C_E21, C_E23, C_V3}; n = 5; end
        4'd12: begin seq = {C_E03, C_E12, C_V2, C_V3, C_NONE}; n = 4; end
        4'd13: begin seq = {C_V0, C_E10, C_E12, C_V2, C_V3}; n = 5; end
        4'd14: begin seq = {C_E01, C_V1, C_V2, C_V3, C_E03}; n = 5; end
        4'd15: begin seq = {C_V0, C_V1, C_V2, C_V3, C_NONE}; n = 4; end
        // nothing above, and the two crossed patterns
        default: n = 0;
      endcase
      return n;
    endfunction

    // accepted quad: queue its clipped polygon
    function void note_quad(quad_t q);
      logic [3:0]      above;
      logic [0:4][3:0] seq;
      int              n;
      int              a;
      int              b;
      vertex_t         v;
      for (int k = 0; k < 4; k++) above[k] = ($signed(q[k].z) > 0);
      n = polygon_of(above, seq);
      if (n == 0) begin
        v = '0;
        v.last = 1'b1;
        expected_vertices.push_back(v);
        return;
      end
      for (int k = 0; k < n; k++) begin
        a = seq[k][3:2];
        b = seq[k][1:0];
        if (a == b) begin
          v.x = q[a].x;
          v.y = q[a].y;
          v.z = q[a].z;
        end else begin
          v.x = edge_coord(q[a].z, q[a].x, q[b].z, q[b].x);
          v.y = edge_coord(q[a].z, q[a].y, q[b].z, q[b].y);
          v.z = edge_coord(q[a].z, q[a].z, q[b].z, q[b].z);
        end
        v.idx  = 3'(k);
        v.cnt  = 3'(n);
        v.last = (k == n - 1);
        expected_vertices.push_back(v);
      end
    endfunction

    // compare one result against the oldest expected vertex
    function void check_vertex(vertex_t got);
      vertex_t exp_v;
      if (expected_vertices.size() == 0) begin
        $error("unexpected vertex x=%0d y=%0d z=%0d index=%0d",
               got.x, got.y, got.z, got.idx);
        mismatch_count++;
        return;
      end
      exp_v = expected_vertices.pop_front();
      if (got.x !== exp_v.x) begin
        $error("out_x: expected %0d, got %0d", exp_v.x, got.x);
        mismatch_count++;
      end
      if (got.y !== exp_v.y) begin
        $error("out_y: expected %0d, got %0d", exp_v.y, got.y);
        mismatch_count++;
      end
      if (got.z !== exp_v.z) begin
        $error("out_z: expected %0d, got %0d", exp_v.z, got.z);
        mismatch_count++;
      end
      if (got.idx !== exp_v.idx) begin
        $error("vertex_index: expected %0d, got %0d", exp_v.idx, got.idx);
        mismatch_count++;
      end
      if (got.cnt !== exp_v.cnt) begin
        $error("vertex_count: expected %0d, got %0d", exp_v.cnt, got.cnt);
        mismatch_count++;
      end
      if (got.last !== exp_v.last) begin
        $error("last_vertex: expected %0d, got %0d", exp_v.last, got.last);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return expected_vertices.size();
    endfunction
  endclass

  logic   clk;
  logic   rst;
  logic   start;
  logic   busy;
  quad_t  quad_in;
  logic   out_valid;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic [2:0] vertex_index;
  logic [2:0] vertex_count;
  logic   last_vertex;

  clip_scoreboard board;
  int cycle_count;
  bit steady;

  quad_horizon_clipper_core uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .v0_x(quad_in[0].x),
    .v0_y(quad_in[0].y),
    .v0_z(quad_in[0].z),
    .v1_x(quad_in[1].x),
    .v1_y(quad_in[1].y),
    .v1_z(quad_in[1].z),
    .v2_x(quad_in[2].x),
    .v2_y(quad_in[2].y),
    .v2_z(quad_in[2].z),
    .v3_x(quad_in[3].x),
    .v3_y(quad_in[3].y),
    .v3_z(quad_in[3].z),
    .out_valid(out_valid),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .vertex_index(vertex_index),
    .vertex_count(vertex_count),
    .last_vertex(last_vertex)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_quad_horizon_clipper_core: done, errors");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid) begin
      board.check_vertex('{x: out_x, y: out_y, z: out_z, idx: vertex_index,
                           cnt: vertex_count, last: last_vertex});
    end
  end

  // coordinate with a bias towards extremes and small magnitudes
  function automatic coord_t any_coord();
    coord_t c;
    case ($urandom_range(0, 9))
      0: c = coord_t'(CMAX);
      1: c = coord_t'(CMIN);
      2: c = coord_t'($urandom_range(0, 2) - 1);
      3, 4: c = coord_t'($urandom_range(0, 1 << 17) - (1 << 16));
      default: c = coord_t'($urandom);
    endcase
    return c;
  endfunction

  // z on the requested side of the horizon; zero counts as below
  function automatic coord_t side_z(bit above);
    coord_t m;
    case ($urandom_range(0, 5))
      0: m = coord_t'(1);
      1: m = coord_t'(CMAX);
      2, 3: m = coord_t'($urandom_range(1, 1 << 16));
      default: m = coord_t'($urandom_range(1, int'(CMAX)));
    endcase
    if (above) return m;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return coord_t'(CMIN);
      default: return -m;
    endcase
  endfunction

  function automatic quad_t quad_for(logic [3:0] above);
    quad_t q;
    for (int k = 0; k < 4; k++) begin
      q[k].x = any_coord();
      q[k].y = any_coord();
      q[k].z = side_z(above[k]);
    end
    return q;
  endfunction

  function automatic quad_t noise_quad();
    quad_t q;
    for (int k = 0; k < 4; k++) begin
      q[k].x = coord_t'($urandom);
      q[k].y = coord_t'($urandom);
      q[k].z = coord_t'($urandom);
    end
    return q;
  endfunction

  // present one quad, with a random gap first unless steady, and hold until taken
  task automatic send_quad(input quad_t q);
    while (!steady && $urandom_range(0, 99) < 35) begin
      @(negedge clk);
      start = 1'b0;
      quad_in = noise_quad();
    end
    @(negedge clk);
    quad_in = q;
    start = 1'b1;
    do @(posedge clk); while (busy);
    board.note_quad(q);
  endtask

  // hold off new quads until every polygon vertex has arrived
  task automatic wait_empty();
    @(negedge clk);
    start = 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    quad_t q;
    board = new();
    cycle_count = 0;
    steady = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    quad_in = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // every sign pattern once
    for (int cfg = 0; cfg < 16; cfg++) send_quad(quad_for(4'(cfg)));

    // all zero, all at the top, all at the bottom
    send_quad('0);
    for (int k = 0; k < 4; k++) q[k] = '{x: coord_t'(CMAX), y: coord_t'(CMAX), z: coord_t'(CMAX)};
    send_quad(q);
    for (int k = 0; k < 4; k++) q[k] = '{x: coord_t'(CMIN), y: coord_t'(CMIN), z: coord_t'(CMIN)};
    send_quad(q);

    // vertex on the plane counts as below
    q = quad_for(4'hf);
    q[0].z = '0;
    send_quad(q);

    // an edge point saturating high on x and low on y
    q = quad_for(4'h1);
    q[0] = '{x: coord_t'(CMAX), y: coord_t'(CMIN), z: coord_t'(CMAX)};
    q[1] = '{x: coord_t'(CMAX), y: coord_t'(CMIN), z: coord_t'(CMIN)};
    q[3] = '{x: coord_t'(CMIN), y: coord_t'(CMAX), z: coord_t'(CMIN)};
    send_quad(q);

    // smallest z either side of the plane
    q = quad_for(4'h5);
    q[0].z = coord_t'(1);
    q[1].z = coord_t'(-1);
    q[2].z = coord_t'(1);
    q[3].z = coord_t'(-1);
    send_quad(q);
    q = quad_for(4'h6);
    q[1].z = coord_t'(1);
    q[2].z = coord_t'(1);
    q[0].z = coord_t'(-1);
    q[3].z = coord_t'(-1);
    send_quad(q);

    wait_empty();

    // random quads, mostly one sign pattern with random content
    for (int i = 0; i < RANDOM_QUADS; i++) begin
      steady = (i >= 150 && i < 250);
      if (i == 300) wait_empty();
      if ($urandom_range(0, 99) < 15) send_quad(noise_quad());
      else send_quad(quad_for(4'($urandom_range(0, 15))));
    end
    steady = 1'b0;

    wait_empty();
    repeat (10) @(posedge clk);
    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("tb_quad_horizon_clipper_core: done, clean");
    end else begin
      $display("tb_quad_horizon_clipper_core: done, errors");
    end
    $finish;
  end

endmodule
